### sv/jsu_pkg.sv
package jsu_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_char;
    logic [2:0]  status;
    logic [15:0] length;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] hex_acc;
    logic [15:0] char_count;
  } dec_state_t;

  // Decoder phases.
  localparam logic [2:0] PH_FINISHED = 3'd0;
  localparam logic [2:0] PH_BODY     = 3'd1;
  localparam logic [2:0] PH_ESCAPE   = 3'd2;
  localparam logic [2:0] PH_HEX1     = 3'd3;
  localparam logic [2:0] PH_HEX2     = 3'd4;
  localparam logic [2:0] PH_HEX3     = 3'd5;
  localparam logic [2:0] PH_HEX4     = 3'd6;

  // Result kinds.
  localparam logic [1:0] K_CHAR = 2'd0;
  localparam logic [1:0] K_DONE = 2'd1;
  localparam logic [1:0] K_FAIL = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOQUOTE = 3'd1;
  localparam logic [2:0] ST_ZERO    = 3'd2;
  localparam logic [2:0] ST_ESCAPE  = 3'd3;
  localparam logic [2:0] ST_HEX     = 3'd4;
  localparam logic [2:0] ST_URANGE  = 3'd5;
  localparam logic [2:0] ST_CONTROL = 3'd6;
  localparam logic [2:0] ST_FULL    = 3'd7;

  // Characters and limits.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6e;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CTRL_LIMIT   = 8'h20;
  localparam logic [7:0] CH_DEL       = 8'h7f;

  localparam logic [15:0] CAPACITY_RESET = 16'd256;
  localparam logic [15:0] CAPACITY_MIN   = 16'd2;

  // Register indexes.
  localparam logic REG_CAPACITY = 1'b0;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

### sv/json_string_unescape.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+--------------------------------------
// in        | input     | in_valid / in_ready  | in_item: data_byte, start_req
// out       | output    | out_valid / out_ready| out_item: kind, out_char, status, length
// config    | input     | APB psel / penable   | paddr, pwdata, prdata (capacity)
//
// One item is accepted per cycle when the output side keeps up; every item passes an
// input register, combinational decode logic and a result register; the result is
// registered when the input register can advance. Reset (rst, synchronous) empties
// both registers, puts the decoder in the finished phase and sets capacity to 256. A
// stalled output holds the result register and the input register in place, and
// in_ready drops only when both are full.
module json_string_unescape import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,

  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration register. Only one register exists, selected by paddr[2] == 0 (byte addresses 0 to 3).
  logic [15:0] capacity;
  logic        cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_write && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {16'd0, capacity} : 32'd0;

  // Input register: holds the accepted item until the decode step has a place
  // to put its result.
  logic       s1_valid;
  in_item_t   s1_item;
  logic       s1_adv;

  assign s1_adv = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  // Decoder state advances only when the registered item is consumed, so the
  // state always reflects exactly the items that have left the input register.
  dec_state_t state;
  dec_state_t state_next;
  logic       res_valid;
  out_item_t  res;

  jsu_step u_step (
    .item      (s1_item),
    .cur       (state),
    .capacity  (capacity),
    .nxt       (state_next),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= PH_FINISHED;
      state.hex_acc    <= '0;
      state.char_count <= '0;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  // Result register. An item that gives no result simply leaves it empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_item <= res;
    end
  end

  // A held item in the input register must not change while it waits.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_item))
    else $error("input register changed while stalled");

  // The unused phase code is never reached.
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    state.phase != 3'd7)
    else $error("decoder reached an undefined phase");

  // A completion or rejection always closes the string.
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    s1_adv && res_valid && res.kind != K_CHAR |=> state.phase == PH_FINISHED)
    else $error("string still open after its final result");

  // A decoded character always counts at least itself.
  a_char_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == K_CHAR |-> out_item.length != 16'd0)
    else $error("character result with zero length");

  // Kind is never the unused code.
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.kind != 2'd3)
    else $error("result with undefined kind");

endmodule

### sv/jsu_step.sv
module jsu_step import jsu_pkg::*; (
  input  in_item_t   item,
  input  dec_state_t cur,
  input  logic [15:0] capacity,
  output dec_state_t nxt,
  output logic       res_valid,
  output out_item_t  res
);

  logic       have_char;
  logic [7:0] char_v;
  logic       fail;
  logic [2:0] fail_st;
  logic [4:0] hd;
  logic [15:0] acc_new;
  logic [16:0] count_inc;

  assign hd = hex_digit(item.data_byte);
  assign acc_new = {cur.hex_acc[11:0], hd[3:0]};
  assign count_inc = {1'b0, cur.char_count} + 17'd1;

  always_comb begin
    nxt = cur;
    res_valid = 1'b0;
    res = '0;
    have_char = 1'b0;
    char_v = '0;
    fail = 1'b0;
    fail_st = ST_OK;

    if (item.start_req) begin
      nxt.phase = PH_FINISHED;
      nxt.hex_acc = '0;
      nxt.char_count = '0;
      if (item.data_byte != CH_QUOTE) begin
        fail = 1'b1;
        fail_st = ST_NOQUOTE;
      end else if (capacity < CAPACITY_MIN) begin
        fail = 1'b1;
        fail_st = ST_FULL;
      end else begin
        nxt.phase = PH_BODY;
      end
    end else if (cur.phase == PH_FINISHED) begin
      // Stray byte between strings: dropped.
    end else if (item.data_byte == 8'd0) begin
      fail = 1'b1;
      fail_st = ST_ZERO;
    end else begin
      case (cur.phase)
        PH_BODY: begin
          if (item.data_byte == CH_QUOTE) begin
            nxt.phase = PH_FINISHED;
            res_valid = 1'b1;
            res.kind = K_DONE;
            res.length = cur.char_count;
          end else if (item.data_byte == CH_BACKSLASH) begin
            nxt.phase = PH_ESCAPE;
          end else begin
            have_char = 1'b1;
            char_v = item.data_byte;
          end
        end
        PH_ESCAPE: begin
          case (item.data_byte)
            CH_U: begin
              nxt.hex_acc = '0;
              nxt.phase = PH_HEX1;
            end
            CH_B: begin
              have_char = 1'b1;
              char_v = 8'h08;
            end
            CH_F: begin
              have_char = 1'b1;
              char_v = 8'h0c;
            end
            CH_N: begin
              have_char = 1'b1;
              char_v = 8'h0a;
            end
            CH_R: begin
              have_char = 1'b1;
              char_v = 8'h0d;
            end
            CH_T: begin
              have_char = 1'b1;
              char_v = 8'h09;
            end
            CH_QUOTE, CH_BACKSLASH, CH_SLASH: begin
              have_char = 1'b1;
              char_v = item.data_byte;
            end
            default: begin
              fail = 1'b1;
              fail_st = ST_ESCAPE;
            end
          endcase
        end
        PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
          if (!hd[4]) begin
            fail = 1'b1;
            fail_st = ST_HEX;
          end else begin
            nxt.hex_acc = acc_new;
            if (cur.phase != PH_HEX4) begin
              nxt.phase = cur.phase + 3'd1;
            end else if (acc_new == 16'd0 || acc_new > {8'd0, CH_DEL}) begin
              fail = 1'b1;
              fail_st = ST_URANGE;
            end else begin
              have_char = 1'b1;
              char_v = acc_new[7:0];
            end
          end
        end
        default: begin
          nxt.phase = PH_FINISHED;
        end
      endcase
    end

    if (have_char) begin
      if (char_v < CTRL_LIMIT || char_v == CH_DEL) begin
        fail = 1'b1;
        fail_st = ST_CONTROL;
      end else if (count_inc >= {1'b0, capacity}) begin
        fail = 1'b1;
        fail_st = ST_FULL;
      end else begin
        nxt.char_count = count_inc[15:0];
        nxt.phase = PH_BODY;
        res_valid = 1'b1;
        res.kind = K_CHAR;
        res.out_char = char_v;
        res.length = count_inc[15:0];
      end
    end

    if (fail) begin
      nxt.phase = PH_FINISHED;
      res_valid = 1'b1;
      res.kind = K_FAIL;
      res.out_char = '0;
      res.status = fail_st;
      res.length = nxt.char_count;
    end
  end

endmodule
